// ----- design/chaotic_map_lfo_assert.svh -----
// Assertion macros shared by the RTL.
`ifndef CHAOTIC_MAP_LFO_ASSERT_SVH
`define CHAOTIC_MAP_LFO_ASSERT_SVH
`ifndef ASSERT_OFF
`define CML_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define CML_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define CML_ASSERT(lbl, clk, rstn, prop, msg)
`define CML_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/cml_pkg.sv -----
package cml_pkg;

  localparam int unsigned STATE_WIDTH  = 32;
  localparam int unsigned FRAC         = 24;
  localparam int unsigned OUT_WIDTH    = 16;
  localparam int unsigned MAX_INTERVAL = 100;
  localparam int unsigned PC_W         = 5;
  localparam int unsigned SM_W         = OUT_WIDTH + 8;

  typedef logic signed [STATE_WIDTH-1:0] sval_t;

  localparam sval_t K_ZERO   = '0;
  localparam sval_t K_ONE    = sval_t'(1 << FRAC);
  localparam sval_t K_HALF   = sval_t'(1 << (FRAC - 1));
  localparam sval_t K_TWO    = sval_t'(2 << FRAC);
  localparam sval_t K_R0     = sval_t'(59894497);
  localparam sval_t K_R1     = sval_t'(7214203);
  localparam sval_t K_SIGMA  = sval_t'(10 << FRAC);
  localparam sval_t K_BETA   = sval_t'(44739243);
  localparam sval_t K_RHO0   = sval_t'(24 << FRAC);
  localparam sval_t K_RHO1   = sval_t'(4 << FRAC);
  localparam sval_t K_DT_LZ  = sval_t'(83886);
  localparam sval_t K_INV20  = sval_t'(838861);
  localparam sval_t K_HA1    = sval_t'(6710886);
  localparam sval_t K_HB     = sval_t'(5033165);
  localparam sval_t K_INV15H = sval_t'(11184811);
  localparam sval_t K_RA     = sval_t'(3355443);
  localparam sval_t K_RC0    = sval_t'(95630131);
  localparam sval_t K_RC1    = sval_t'(72142029);
  localparam sval_t K_DT_RS  = sval_t'(167772);
  localparam sval_t K_INV15  = sval_t'(1118481);

  typedef enum logic [2:0] {
    MAP_LOGISTIC = 3'd0,
    MAP_LORENZ   = 3'd1,
    MAP_HENON    = 3'd2,
    MAP_TENT     = 3'd3,
    MAP_ROSSLER  = 3'd4
  } map_e;

  typedef enum logic [2:0] {
    REG_MAP_SELECT      = 3'd0,
    REG_CHAOS_AMOUNT    = 3'd1,
    REG_UPDATE_INTERVAL = 3'd2,
    REG_SMOOTHING_COEF  = 3'd3,
    REG_OUTPUT_DEPTH    = 3'd4,
    REG_INITIAL_X       = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_NSUB, OP_MIN, OP_MUL
  } op_e;

  typedef enum logic [4:0] {
    S_X, S_Y, S_Z, S_T0, S_T1, S_T2, S_T3, S_AMT, S_ZERO, S_ONE, S_HALF, S_TWO,
    S_R0, S_R1, S_SIGMA, S_BETA, S_RHO0, S_RHO1, S_DTLZ, S_INV20, S_HA1, S_HB,
    S_INV15H, S_RA, S_RC0, S_RC1, S_DTRS, S_INV15
  } src_e;

  typedef enum logic [2:0] {
    D_X, D_Y, D_Z, D_T0, D_T1, D_T2, D_T3
  } dst_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    dst_e d;
    logic last;
  } uop_t;

  typedef struct packed {
    logic start;
    logic restart;
  } seq_ctl_t;

  typedef enum logic [2:0] {
    T_IDLE, T_CSTART, T_CWAIT, T_SSTART, T_SWAIT, T_DONE
  } top_state_e;

  typedef enum logic [1:0] {
    CH_IDLE, CH_EXEC, CH_MULW
  } chs_state_e;

  typedef enum logic [2:0] {
    SM_IDLE, SM_MTGT, SM_TGT, SM_MA, SM_MB, SM_FIN
  } smo_state_e;

  function automatic uop_t uop(op_e op, src_e a, src_e b, dst_e d, logic last);
    uop_t u;
    u.op   = op;
    u.a    = a;
    u.b    = b;
    u.d    = d;
    u.last = last;
    return u;
  endfunction

  // Microprogram: one step of each map. The final op always lands in t0.
  function automatic uop_t ucode(logic [2:0] map, logic [PC_W-1:0] pc);
    uop_t u;
    u = uop(OP_ADD, S_ZERO, S_ZERO, D_T0, 1'b1);
    unique case (map)
      MAP_LOGISTIC: begin
        unique case (pc)
          5'd0:    u = uop(OP_MUL, S_AMT,  S_R1,   D_T0, 1'b0);
          5'd1:    u = uop(OP_ADD, S_R0,   S_T0,   D_T0, 1'b0);
          5'd2:    u = uop(OP_MUL, S_T0,   S_X,    D_T0, 1'b0);
          5'd3:    u = uop(OP_SUB, S_ONE,  S_X,    D_T1, 1'b0);
          5'd4:    u = uop(OP_MUL, S_T0,   S_T1,   D_X,  1'b0);
          5'd5:    u = uop(OP_SUB, S_X,    S_HALF, D_T0, 1'b0);
          default: u = uop(OP_MUL, S_T0,   S_TWO,  D_T0, 1'b1);
        endcase
      end
      MAP_LORENZ: begin
        unique case (pc)
          5'd0:    u = uop(OP_MUL, S_AMT,   S_RHO1, D_T0, 1'b0);
          5'd1:    u = uop(OP_ADD, S_RHO0,  S_T0,   D_T0, 1'b0);
          5'd2:    u = uop(OP_SUB, S_Y,     S_X,    D_T1, 1'b0);
          5'd3:    u = uop(OP_MUL, S_SIGMA, S_T1,   D_T1, 1'b0);
          5'd4:    u = uop(OP_SUB, S_T0,    S_Z,    D_T2, 1'b0);
          5'd5:    u = uop(OP_MUL, S_X,     S_T2,   D_T2, 1'b0);
          5'd6:    u = uop(OP_SUB, S_T2,    S_Y,    D_T2, 1'b0);
          5'd7:    u = uop(OP_MUL, S_X,     S_Y,    D_T3, 1'b0);
          5'd8:    u = uop(OP_MUL, S_BETA,  S_Z,    D_T0, 1'b0);
          5'd9:    u = uop(OP_SUB, S_T3,    S_T0,   D_T3, 1'b0);
          5'd10:   u = uop(OP_MUL, S_T1,    S_DTLZ, D_T1, 1'b0);
          5'd11:   u = uop(OP_ADD, S_X,     S_T1,   D_X,  1'b0);
          5'd12:   u = uop(OP_MUL, S_T2,    S_DTLZ, D_T2, 1'b0);
          5'd13:   u = uop(OP_ADD, S_Y,     S_T2,   D_Y,  1'b0);
          5'd14:   u = uop(OP_MUL, S_T3,    S_DTLZ, D_T3, 1'b0);
          5'd15:   u = uop(OP_ADD, S_Z,     S_T3,   D_Z,  1'b0);
          default: u = uop(OP_MUL, S_X,     S_INV20, D_T0, 1'b1);
        endcase
      end
      MAP_HENON: begin
        unique case (pc)
          5'd0:    u = uop(OP_MUL, S_AMT, S_HA1,  D_T0, 1'b0);
          5'd1:    u = uop(OP_ADD, S_ONE, S_T0,   D_T0, 1'b0);
          5'd2:    u = uop(OP_MUL, S_X,   S_X,    D_T1, 1'b0);
          5'd3:    u = uop(OP_MUL, S_T0,  S_T1,   D_T1, 1'b0);
          5'd4:    u = uop(OP_SUB, S_ONE, S_T1,   D_T1, 1'b0);
          5'd5:    u = uop(OP_MUL, S_HB,  S_X,    D_T2, 1'b0);
          5'd6:    u = uop(OP_ADD, S_T1,  S_Y,    D_X,  1'b0);
          5'd7:    u = uop(OP_ADD, S_T2,  S_ZERO, D_Y,  1'b0);
          default: u = uop(OP_MUL, S_X,   S_INV15H, D_T0, 1'b1);
        endcase
      end
      MAP_TENT: begin
        unique case (pc)
          5'd0:    u = uop(OP_ADD, S_ONE, S_AMT,  D_T0, 1'b0);
          5'd1:    u = uop(OP_SUB, S_ONE, S_X,    D_T1, 1'b0);
          5'd2:    u = uop(OP_MIN, S_X,   S_T1,   D_T1, 1'b0);
          5'd3:    u = uop(OP_MUL, S_T0,  S_T1,   D_X,  1'b0);
          5'd4:    u = uop(OP_SUB, S_X,   S_HALF, D_T0, 1'b0);
          default: u = uop(OP_MUL, S_T0,  S_TWO,  D_T0, 1'b1);
        endcase
      end
      MAP_ROSSLER: begin
        unique case (pc)
          5'd0:    u = uop(OP_MUL,  S_AMT, S_RC1,  D_T0, 1'b0);
          5'd1:    u = uop(OP_ADD,  S_RC0, S_T0,   D_T0, 1'b0);
          5'd2:    u = uop(OP_NSUB, S_Y,   S_Z,    D_T1, 1'b0);
          5'd3:    u = uop(OP_MUL,  S_RA,  S_Y,    D_T2, 1'b0);
          5'd4:    u = uop(OP_ADD,  S_X,   S_T2,   D_T2, 1'b0);
          5'd5:    u = uop(OP_SUB,  S_X,   S_T0,   D_T3, 1'b0);
          5'd6:    u = uop(OP_MUL,  S_Z,   S_T3,   D_T3, 1'b0);
          5'd7:    u = uop(OP_ADD,  S_RA,  S_T3,   D_T3, 1'b0);
          5'd8:    u = uop(OP_MUL,  S_T1,  S_DTRS, D_T1, 1'b0);
          5'd9:    u = uop(OP_ADD,  S_X,   S_T1,   D_X,  1'b0);
          5'd10:   u = uop(OP_MUL,  S_T2,  S_DTRS, D_T2, 1'b0);
          5'd11:   u = uop(OP_ADD,  S_Y,   S_T2,   D_Y,  1'b0);
          5'd12:   u = uop(OP_MUL,  S_T3,  S_DTRS, D_T3, 1'b0);
          5'd13:   u = uop(OP_ADD,  S_Z,   S_T3,   D_Z,  1'b0);
          default: u = uop(OP_MUL,  S_X,   S_INV15, D_T0, 1'b1);
        endcase
      end
      default: u = uop(OP_ADD, S_ZERO, S_ZERO, D_T0, 1'b1);
    endcase
    return u;
  endfunction

  // Clamp to +-1, then map Q.24 to Q1.(OUT_WIDTH-1) by floor, top code capped.
  function automatic logic signed [OUT_WIDTH-1:0] to_out(sval_t v);
    sval_t c;
    sval_t s;
    logic [OUT_WIDTH:0] u;
    if (v > K_ONE) begin
      c = K_ONE;
    end else if (v < -K_ONE) begin
      c = -K_ONE;
    end else begin
      c = v;
    end
    s = c + K_ONE;
    u = s[FRAC+1 -: OUT_WIDTH+1];
    if (u[OUT_WIDTH]) begin
      return {1'b0, {(OUT_WIDTH-1){1'b1}}};
    end
    return {~u[OUT_WIDTH-1], u[OUT_WIDTH-2:0]};
  endfunction

endpackage

// ----- design/cml_alu.sv -----
// Shared saturating unit: add/sub/nsub/min combinational, multiply through a register.
module cml_alu (
  input  logic              clk_i,
  input  cml_pkg::op_e      op_i,
  input  cml_pkg::sval_t    a_i,
  input  cml_pkg::sval_t    b_i,
  output cml_pkg::sval_t    res_o,
  output cml_pkg::sval_t    mul_o
);

  localparam int unsigned SW = cml_pkg::STATE_WIDTH;
  localparam int unsigned QW = 2 * SW - cml_pkg::FRAC;
  localparam logic [QW-1:0] QLIM = QW'(1) << (SW - 1);

  logic signed [SW+1:0] wide;
  logic [SW-1:0]        mag_a;
  logic [SW-1:0]        mag_b;
  logic [2*SW-1:0]      prod_q;
  logic                 neg_q;
  logic [QW-1:0]        q;

  always_comb begin
    case (op_i)
      cml_pkg::OP_ADD:  wide = (SW+2)'(a_i) + (SW+2)'(b_i);
      cml_pkg::OP_SUB:  wide = (SW+2)'(a_i) - (SW+2)'(b_i);
      cml_pkg::OP_NSUB: wide = -(SW+2)'(a_i) - (SW+2)'(b_i);
      cml_pkg::OP_MIN:  wide = (a_i < b_i) ? (SW+2)'(a_i) : (SW+2)'(b_i);
      default:          wide = '0;
    endcase
    if (wide > (SW+2)'($signed({1'b0, {(SW-1){1'b1}}}))) begin
      res_o = {1'b0, {(SW-1){1'b1}}};
    end else if (wide < -(SW+2)'($signed({2'b0, 1'b1, {(SW-1){1'b0}}}))) begin
      res_o = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_o = wide[SW-1:0];
    end
  end

  assign mag_a = a_i[SW-1] ? $unsigned(-a_i) : $unsigned(a_i);
  assign mag_b = b_i[SW-1] ? $unsigned(-b_i) : $unsigned(b_i);

  always_ff @(posedge clk_i) begin
    prod_q <= mag_a * mag_b;
    neg_q  <= a_i[SW-1] ^ b_i[SW-1];
  end

  // magnitude truncates toward zero, then saturates by sign
  assign q = prod_q[2*SW-1:cml_pkg::FRAC];

  always_comb begin
    if (neg_q) begin
      mul_o = (q >= QLIM) ? {1'b1, {(SW-1){1'b0}}} : -$signed(q[SW-1:0]);
    end else begin
      mul_o = (q >= QLIM) ? {1'b0, {(SW-1){1'b1}}} : $signed(q[SW-1:0]);
    end
  end

endmodule

// ----- design/cml_chaos.sv -----
// Map state and microsequencer around the shared unit.
module cml_chaos (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cml_pkg::seq_ctl_t                     ctl_i,
  input  logic [2:0]                            map_sel_i,
  input  logic [15:0]                           amt_i,
  input  logic [23:0]                           init_x_i,
  output logic                                  done_o,
  output logic signed [cml_pkg::OUT_WIDTH-1:0]  raw_o
);

  localparam int unsigned PW = cml_pkg::PC_W;

  cml_pkg::chs_state_e st_q, st_d;
  logic [PW-1:0]       pc_q, pc_d;
  cml_pkg::sval_t      x_q, y_q, z_q, t0_q, t1_q, t2_q, t3_q;
  cml_pkg::sval_t      opa, opb, res, mulr, wb;
  cml_pkg::uop_t       u;
  logic                we;
  logic signed [cml_pkg::OUT_WIDTH-1:0] raw_q;

  function automatic cml_pkg::sval_t pick(cml_pkg::src_e s);
    cml_pkg::sval_t v;
    unique case (s)
      cml_pkg::S_X:      v = x_q;
      cml_pkg::S_Y:      v = y_q;
      cml_pkg::S_Z:      v = z_q;
      cml_pkg::S_T0:     v = t0_q;
      cml_pkg::S_T1:     v = t1_q;
      cml_pkg::S_T2:     v = t2_q;
      cml_pkg::S_T3:     v = t3_q;
      cml_pkg::S_AMT:    v = cml_pkg::sval_t'({amt_i, 8'h00});
      cml_pkg::S_ZERO:   v = cml_pkg::K_ZERO;
      cml_pkg::S_ONE:    v = cml_pkg::K_ONE;
      cml_pkg::S_HALF:   v = cml_pkg::K_HALF;
      cml_pkg::S_TWO:    v = cml_pkg::K_TWO;
      cml_pkg::S_R0:     v = cml_pkg::K_R0;
      cml_pkg::S_R1:     v = cml_pkg::K_R1;
      cml_pkg::S_SIGMA:  v = cml_pkg::K_SIGMA;
      cml_pkg::S_BETA:   v = cml_pkg::K_BETA;
      cml_pkg::S_RHO0:   v = cml_pkg::K_RHO0;
      cml_pkg::S_RHO1:   v = cml_pkg::K_RHO1;
      cml_pkg::S_DTLZ:   v = cml_pkg::K_DT_LZ;
      cml_pkg::S_INV20:  v = cml_pkg::K_INV20;
      cml_pkg::S_HA1:    v = cml_pkg::K_HA1;
      cml_pkg::S_HB:     v = cml_pkg::K_HB;
      cml_pkg::S_INV15H: v = cml_pkg::K_INV15H;
      cml_pkg::S_RA:     v = cml_pkg::K_RA;
      cml_pkg::S_RC0:    v = cml_pkg::K_RC0;
      cml_pkg::S_RC1:    v = cml_pkg::K_RC1;
      cml_pkg::S_DTRS:   v = cml_pkg::K_DT_RS;
      cml_pkg::S_INV15:  v = cml_pkg::K_INV15;
      default:           v = cml_pkg::K_ZERO;
    endcase
    return v;
  endfunction

  assign u   = cml_pkg::ucode(map_sel_i, pc_q);
  assign opa = pick(u.a);
  assign opb = pick(u.b);

  cml_alu u_alu (
    .clk_i (clk_i),
    .op_i  (u.op),
    .a_i   (opa),
    .b_i   (opb),
    .res_o (res),
    .mul_o (mulr)
  );

  assign wb = (st_q == cml_pkg::CH_MULW) ? mulr : res;

  always_comb begin
    st_d   = st_q;
    pc_d   = pc_q;
    we     = 1'b0;
    done_o = 1'b0;
    unique case (st_q)
      cml_pkg::CH_IDLE: begin
        if (ctl_i.start) begin
          st_d = cml_pkg::CH_EXEC;
          pc_d = '0;
        end
      end
      cml_pkg::CH_EXEC: begin
        if (u.op == cml_pkg::OP_MUL) begin
          st_d = cml_pkg::CH_MULW;
        end else begin
          we = 1'b1;
        end
      end
      cml_pkg::CH_MULW: begin
        we   = 1'b1;
        st_d = cml_pkg::CH_EXEC;
      end
      default: st_d = cml_pkg::CH_IDLE;
    endcase
    if (we) begin
      if (u.last) begin
        done_o = 1'b1;
        st_d   = cml_pkg::CH_IDLE;
      end else begin
        pc_d = pc_q + PW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cml_pkg::CH_IDLE;
      pc_q <= '0;
    end else begin
      st_q <= st_d;
      pc_q <= pc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= cml_pkg::K_HALF;
      y_q   <= cml_pkg::K_HALF;
      z_q   <= cml_pkg::K_HALF;
      raw_q <= '0;
    end else if (ctl_i.restart) begin
      x_q   <= cml_pkg::sval_t'(init_x_i);
      y_q   <= cml_pkg::K_HALF;
      z_q   <= cml_pkg::K_HALF;
      raw_q <= '0;
    end else if (we) begin
      if (u.d == cml_pkg::D_X) x_q <= wb;
      if (u.d == cml_pkg::D_Y) y_q <= wb;
      if (u.d == cml_pkg::D_Z) z_q <= wb;
      if (u.last) raw_q <= cml_pkg::to_out(wb);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      if (u.d == cml_pkg::D_T0) t0_q <= wb;
      if (u.d == cml_pkg::D_T1) t1_q <= wb;
      if (u.d == cml_pkg::D_T2) t2_q <= wb;
      if (u.d == cml_pkg::D_T3) t3_q <= wb;
    end
  end

  assign raw_o = raw_q;

endmodule

// ----- design/cml_smooth.sv -----
// Depth scaling and one-pole smoother sharing one multiplier.
module cml_smooth (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  cml_pkg::seq_ctl_t                     ctl_i,
  input  logic signed [cml_pkg::OUT_WIDTH-1:0]  raw_i,
  input  logic [15:0]                           depth_i,
  input  logic [15:0]                           coef_i,
  output logic                                  done_o,
  output logic signed [cml_pkg::OUT_WIDTH-1:0]  lfo_o
);

  localparam int unsigned OW  = cml_pkg::OUT_WIDTH;
  localparam int unsigned SMW = cml_pkg::SM_W;
  localparam int unsigned PRW = SMW + 17;

  cml_pkg::smo_state_e  st_q, st_d;
  logic signed [SMW-1:0] sm_q, tgt_q, tgt_w, sm_fin;
  logic signed [SMW:0]   tgt_wide;
  logic [SMW-1:0]        ma;
  logic [16:0]           mb;
  logic [PRW-1:0]        prod_q, acc_q, sum;

  always_comb begin
    case (st_q)
      cml_pkg::SM_MA: begin
        ma = {~sm_q[SMW-1], sm_q[SMW-2:0]};
        mb = {1'b0, coef_i};
      end
      cml_pkg::SM_MB: begin
        ma = {~tgt_q[SMW-1], tgt_q[SMW-2:0]};
        mb = 17'h10000 - {1'b0, coef_i};
      end
      default: begin
        ma = {{(SMW-OW){1'b0}}, ~raw_i[OW-1], raw_i[OW-2:0]};
        mb = {1'b0, depth_i};
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PRW'(ma) * PRW'(mb);
    if (st_q == cml_pkg::SM_MB) acc_q <= prod_q;
    if (st_q == cml_pkg::SM_TGT) tgt_q <= tgt_w;
  end

  assign tgt_wide = $signed({1'b0, prod_q[OW+15:8]})
                  - $signed({2'b00, depth_i, {(OW-9){1'b0}}});
  assign tgt_w    = tgt_wide[SMW-1:0];
  assign sum      = acc_q + prod_q;
  assign sm_fin   = {~sum[SMW+15], sum[SMW+14:16]};

  always_comb begin
    st_d   = st_q;
    done_o = 1'b0;
    unique case (st_q)
      cml_pkg::SM_IDLE: if (ctl_i.start) st_d = cml_pkg::SM_MTGT;
      cml_pkg::SM_MTGT: st_d = cml_pkg::SM_TGT;
      cml_pkg::SM_TGT: begin
        if (coef_i == '0) begin
          done_o = 1'b1;
          st_d   = cml_pkg::SM_IDLE;
        end else begin
          st_d = cml_pkg::SM_MA;
        end
      end
      cml_pkg::SM_MA:   st_d = cml_pkg::SM_MB;
      cml_pkg::SM_MB:   st_d = cml_pkg::SM_FIN;
      cml_pkg::SM_FIN: begin
        done_o = 1'b1;
        st_d   = cml_pkg::SM_IDLE;
      end
      default: st_d = cml_pkg::SM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= cml_pkg::SM_IDLE;
      sm_q <= '0;
    end else begin
      st_q <= st_d;
      if (ctl_i.restart) begin
        sm_q <= '0;
      end else if (st_q == cml_pkg::SM_TGT && coef_i == '0) begin
        sm_q <= tgt_w;
      end else if (st_q == cml_pkg::SM_FIN) begin
        sm_q <= sm_fin;
      end
    end
  end

  assign lfo_o = sm_q[SMW-1:8];

endmodule

// ----- design/chaotic_map_lfo.sv -----
// Chaotic modulation oscillator, one tick per input transfer.
// Input channel (in_valid_i/in_ready_o) carries advance_i and restart_orbit_i;
// every input transfer yields exactly one output transfer on out_valid_o /
// out_ready_i with lfo_value_o (smoothed, depth-scaled) and raw_value_o.
// Config channel (cfg_valid_i/cfg_ready_o) writes register cfg_index_i with
// cfg_data_i; it is always ready. The user must write it only while the block
// is idle; the block itself does not enforce this. Advance low: output load
// only. Advance without a map step: smoother only. Step tick: map sequencer,
// then smoother (Lorenz, the longest map, runs 17 micro-ops, 9 of them
// multiplies). Work rests on the one shared 32x32 saturating multiply/add unit
// in the map sequencer and the smoother's multiplier, used up to three times.
// One item is in flight at a time; in_ready_o is high only when idle.
// Results sit in an output register, so the next input can be taken while
// a result waits; a stalled receiver holds the block in its final state
// until that register frees up.
// Reset: registers take their documented defaults, x = initial_x, y = z = 0.5,
// raw, smoothed output and the step countdown are zero.
`include "chaotic_map_lfo_assert.svh"
module chaotic_map_lfo #(
  parameter int unsigned MAX_INTERVAL = cml_pkg::MAX_INTERVAL
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  advance_i,
  input  logic                                  restart_orbit_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [cml_pkg::OUT_WIDTH-1:0]  lfo_value_o,
  output logic signed [cml_pkg::OUT_WIDTH-1:0]  raw_value_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [2:0]                            cfg_index_i,
  input  logic [23:0]                           cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_INTERVAL + 1);

  // configuration registers
  logic [2:0]  map_sel_q;
  logic [15:0] amt_q;
  logic [6:0]  interval_q;
  logic [15:0] coef_q;
  logic [15:0] depth_q;
  logic [23:0] init_x_q;

  cml_pkg::top_state_e st_q, st_d;
  logic [CW-1:0]       cnt_q, cnt_d, cnt_eff, reload;
  cml_pkg::seq_ctl_t   chs_ctl, smo_ctl;
  logic                chs_done, smo_done;
  logic                accept, load_out;
  logic                out_valid_q;
  logic signed [cml_pkg::OUT_WIDTH-1:0] lfo_q, raw_q, chs_raw, smo_lfo;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (st_q == cml_pkg::T_IDLE);
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_sel_q  <= 3'd0;
      amt_q      <= 16'd32768;
      interval_q <= 7'd50;
      coef_q     <= 16'd0;
      depth_q    <= 16'd65535;
      init_x_q   <= 24'd8388608;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        cml_pkg::REG_MAP_SELECT:      map_sel_q  <= cfg_data_i[2:0];
        cml_pkg::REG_CHAOS_AMOUNT:    amt_q      <= cfg_data_i[15:0];
        cml_pkg::REG_UPDATE_INTERVAL: interval_q <= cfg_data_i[6:0];
        cml_pkg::REG_SMOOTHING_COEF:  coef_q     <= cfg_data_i[15:0];
        cml_pkg::REG_OUTPUT_DEPTH:    depth_q    <= cfg_data_i[15:0];
        cml_pkg::REG_INITIAL_X:       init_x_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // countdown reload: zero acts as one, large values clip to the maximum
  always_comb begin
    if (interval_q == '0) begin
      reload = CW'(1);
    end else if (32'(interval_q) > 32'(MAX_INTERVAL)) begin
      reload = CW'(MAX_INTERVAL);
    end else begin
      reload = CW'(interval_q);
    end
  end

  assign cnt_eff = restart_orbit_i ? '0 : cnt_q;

  always_comb begin
    st_d     = st_q;
    cnt_d    = cnt_q;
    chs_ctl  = '0;
    smo_ctl  = '0;
    load_out = 1'b0;
    unique case (st_q)
      cml_pkg::T_IDLE: begin
        if (accept) begin
          // restart takes effect before this tick's work
          chs_ctl.restart = restart_orbit_i;
          smo_ctl.restart = restart_orbit_i;
          if (!advance_i) begin
            cnt_d = cnt_eff;
            st_d  = cml_pkg::T_DONE;
          end else if (cnt_eff == '0) begin
            cnt_d = reload;
            st_d  = cml_pkg::T_CSTART;
          end else begin
            cnt_d = cnt_eff - CW'(1);
            st_d  = cml_pkg::T_SSTART;
          end
        end
      end
      cml_pkg::T_CSTART: begin
        chs_ctl.start = 1'b1;
        st_d          = cml_pkg::T_CWAIT;
      end
      cml_pkg::T_CWAIT: if (chs_done) st_d = cml_pkg::T_SSTART;
      cml_pkg::T_SSTART: begin
        smo_ctl.start = 1'b1;
        st_d          = cml_pkg::T_SWAIT;
      end
      cml_pkg::T_SWAIT: if (smo_done) st_d = cml_pkg::T_DONE;
      cml_pkg::T_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          st_d     = cml_pkg::T_IDLE;
        end
      end
      default: st_d = cml_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= cml_pkg::T_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      lfo_q <= smo_lfo;
      raw_q <= chs_raw;
    end
  end

  cml_chaos u_chaos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (chs_ctl),
    .map_sel_i (map_sel_q),
    .amt_i     (amt_q),
    .init_x_i  (init_x_q),
    .done_o    (chs_done),
    .raw_o     (chs_raw)
  );

  cml_smooth u_smooth (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (smo_ctl),
    .raw_i   (chs_raw),
    .depth_i (depth_q),
    .coef_i  (coef_q),
    .done_o  (smo_done),
    .lfo_o   (smo_lfo)
  );

  assign out_valid_o = out_valid_q;
  assign lfo_value_o = lfo_q;
  assign raw_value_o = raw_q;

  `CML_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> !in_ready_o, "ready after accept")
  `CML_ASSERT(a_cnt_range, clk_i, rst_ni, 32'(cnt_q) <= 32'(MAX_INTERVAL), "countdown range")
  `CML_ASSERT_IMP(a_chs_done, clk_i, rst_ni, chs_done, st_q == cml_pkg::T_CWAIT, "stray map done")
  `CML_ASSERT_IMP(a_smo_done, clk_i, rst_ni, smo_done, st_q == cml_pkg::T_SWAIT, "stray smooth done")
  `CML_ASSERT(a_out_load, clk_i, rst_ni, $rose(out_valid_q) |-> $past(st_q == cml_pkg::T_DONE), "load")

endmodule

// ----- sim/tb_top.sv -----
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // Q8.24 arithmetic limits, mirrored at 64 bits for headroom
  localparam longint LIM      = longint'(1) <<< 31;
  localparam longint ONE_Q    = longint'(1) <<< 24;
  localparam longint HALF_Q   = longint'(1) <<< 23;
  localparam longint HALF_OUT = longint'(1) <<< 15;
  localparam longint SM_OFF   = longint'(1) <<< 23;
  localparam int     N_RANDOM = 750;
  localparam longint CYCLE_LIMIT = 400000;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic advance_i;
  logic restart_orbit_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [cml_pkg::OUT_WIDTH-1:0] lfo_value_o;
  logic signed [cml_pkg::OUT_WIDTH-1:0] raw_value_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i;
  logic [23:0] cfg_data_i;

  chaotic_map_lfo DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Predictor state: register copies and orbit state
  int unsigned map_r, amount_r, interval_r, coef_r, depth_r, init_x_r;
  longint orbit_x, orbit_y, orbit_z, raw_hold, smooth_acc;
  int unsigned countdown;

  typedef struct {
    logic signed [cml_pkg::OUT_WIDTH-1:0] lfo;
    logic signed [cml_pkg::OUT_WIDTH-1:0] raw;
  } lfo_result_t;

  lfo_result_t pending_results[$];
  int  n_mismatch;
  int  n_results;
  int  n_steps;
  int  send_idle_pct;
  int  recv_idle_pct;
  longint cycle_count;

  function automatic longint sat(longint v);
    if (v > LIM - 1) return LIM - 1;
    if (v < -LIM) return -LIM;
    return v;
  endfunction

  function automatic longint qadd(longint a, longint b);
    return sat(a + b);
  endfunction

  function automatic longint qsub(longint a, longint b);
    return sat(a - b);
  endfunction

  // Sign-magnitude product, magnitude truncated, saturated both sides
  function automatic longint qmul(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, ah, al, bh, bl, hh, m;
    neg = (a < 0) != (b < 0);
    ua = (a < 0) ? -a : a;
    ub = (b < 0) ? -b : b;
    ah = ua >> 24;
    al = ua & (ONE_Q - 1);
    bh = ub >> 24;
    bl = ub & (ONE_Q - 1);
    hh = ah * bh;
    if (hh > (LIM >> 24)) begin
      m = LIM;
    end else begin
      m = (hh << 24) + ah * bl + al * bh + ((al * bl) >> 24);
      if (m > LIM) m = LIM;
    end
    if (neg) return -longint'(m);
    return (m > LIM - 1) ? LIM - 1 : longint'(m);
  endfunction

  function automatic longint norm_to_q15(longint v);
    longint c, r;
    c = (v > ONE_Q) ? ONE_Q : ((v < -ONE_Q) ? -ONE_Q : v);
    r = ((c + ONE_Q) >>> 9) - HALF_OUT;
    return (r > HALF_OUT - 1) ? HALF_OUT - 1 : r;
  endfunction

  // One step of the selected chaotic system; returns the new raw value
  function automatic longint advance_orbit();
    longint amt, x, y, z, p, dx, dy, dz;
    amt = longint'(amount_r) <<< 8;
    x = orbit_x;
    y = orbit_y;
    z = orbit_z;
    case (map_r)
      cml_pkg::MAP_LOGISTIC: begin
        p = qadd(cml_pkg::K_R0, qmul(amt, cml_pkg::K_R1));
        orbit_x = qmul(qmul(p, x), qsub(ONE_Q, x));
        return norm_to_q15(qmul(qsub(orbit_x, HALF_Q), 2 * ONE_Q));
      end
      cml_pkg::MAP_LORENZ: begin
        p = qadd(cml_pkg::K_RHO0, qmul(amt, cml_pkg::K_RHO1));
        dx = qmul(cml_pkg::K_SIGMA, qsub(y, x));
        dy = qsub(qmul(x, qsub(p, z)), y);
        dz = qsub(qmul(x, y), qmul(cml_pkg::K_BETA, z));
        orbit_x = qadd(x, qmul(dx, cml_pkg::K_DT_LZ));
        orbit_y = qadd(y, qmul(dy, cml_pkg::K_DT_LZ));
        orbit_z = qadd(z, qmul(dz, cml_pkg::K_DT_LZ));
        return norm_to_q15(qmul(orbit_x, cml_pkg::K_INV20));
      end
      cml_pkg::MAP_HENON: begin
        p = qadd(ONE_Q, qmul(amt, cml_pkg::K_HA1));
        orbit_x = qadd(qsub(ONE_Q, qmul(p, qmul(x, x))), y);
        orbit_y = qmul(cml_pkg::K_HB, x);
        return norm_to_q15(qmul(orbit_x, cml_pkg::K_INV15H));
      end
      cml_pkg::MAP_TENT: begin
        p = qadd(ONE_Q, amt);
        dx = qsub(ONE_Q, x);
        orbit_x = qmul(p, (x < dx) ? x : dx);
        return norm_to_q15(qmul(qsub(orbit_x, HALF_Q), 2 * ONE_Q));
      end
      cml_pkg::MAP_ROSSLER: begin
        p = qadd(cml_pkg::K_RC0, qmul(amt, cml_pkg::K_RC1));
        dx = qsub(-y, z);
        dy = qadd(x, qmul(cml_pkg::K_RA, y));
        dz = qadd(cml_pkg::K_RA, qmul(z, qsub(x, p)));
        orbit_x = qadd(x, qmul(dx, cml_pkg::K_DT_RS));
        orbit_y = qadd(y, qmul(dy, cml_pkg::K_DT_RS));
        orbit_z = qadd(z, qmul(dz, cml_pkg::K_DT_RS));
        return norm_to_q15(qmul(orbit_x, cml_pkg::K_INV15));
      end
      default: return 0;
    endcase
  endfunction

  function automatic void reload_orbit();
    orbit_x = init_x_r;
    orbit_y = HALF_Q;
    orbit_z = HALF_Q;
    raw_hold = 0;
    smooth_acc = 0;
    countdown = 0;
  endfunction

  function automatic void apply_reg(cml_pkg::cfg_reg_e idx, int unsigned val);
    case (idx)
      cml_pkg::REG_MAP_SELECT:      map_r = val & 7;
      cml_pkg::REG_CHAOS_AMOUNT:    amount_r = val & 16'hFFFF;
      cml_pkg::REG_UPDATE_INTERVAL: interval_r = val & 7'h7F;
      cml_pkg::REG_SMOOTHING_COEF:  coef_r = val & 16'hFFFF;
      cml_pkg::REG_OUTPUT_DEPTH:    depth_r = val & 16'hFFFF;
      cml_pkg::REG_INITIAL_X:       init_x_r = val & 24'hFFFFFF;
      default: ;
    endcase
  endfunction

  // Tick of the oscillator: restart, countdown/step, smoother, output
  function automatic lfo_result_t predict_tick(bit adv, bit rst_orbit);
    lfo_result_t r;
    int unsigned iv;
    longint target;
    longint unsigned a, b;
    if (rst_orbit) reload_orbit();
    if (adv) begin
      if (countdown == 0) begin
        iv = interval_r;
        if (iv < 1) iv = 1;
        if (iv > cml_pkg::MAX_INTERVAL) iv = cml_pkg::MAX_INTERVAL;
        raw_hold = advance_orbit();
        countdown = iv;
        n_steps++;
      end else begin
        countdown--;
      end
      target = longint'((longint'(raw_hold + HALF_OUT) * longint'(depth_r)) >>> 8)
               - (longint'(depth_r) <<< 7);
      if (coef_r == 0) begin
        smooth_acc = target;
      end else begin
        a = smooth_acc + SM_OFF;
        b = target + SM_OFF;
        smooth_acc = longint'((a * coef_r + b * (65536 - coef_r)) >> 16) - SM_OFF;
      end
    end
    r.lfo = cml_pkg::OUT_WIDTH'(((smooth_acc + SM_OFF) >>> 8) - (SM_OFF >>> 8));
    r.raw = cml_pkg::OUT_WIDTH'(raw_hold);
    return r;
  endfunction

  // Register write; only called with nothing outstanding
  task automatic write_reg(cml_pkg::cfg_reg_e idx, int unsigned val);
    cfg_index_i <= idx;
    cfg_data_i  <= val[23:0];
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk_i);
  endtask

  // One tick transfer; expectation queued when the transfer happens.
  // The block is busy after a transfer (in_ready_o drops), so the
  // trailing low of in_valid_i costs no throughput.
  task automatic send_tick(bit adv, bit rst_orbit);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) @(posedge clk_i);
    advance_i       <= adv;
    restart_orbit_i <= rst_orbit;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_tick(adv, rst_orbit));
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Directed rows: expected values filled in only where obvious
  task automatic check_known(lfo_result_t want);
    lfo_result_t got;
    got = pending_results[$];
    if (got.lfo !== want.lfo || got.raw !== want.raw) begin
      n_mismatch++;
      if (n_mismatch <= 10)
        $display("predictor disagrees with table: lfo %0d/%0d raw %0d/%0d",
                 got.lfo, want.lfo, got.raw, want.raw);
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  // Receiver side: random stalls and checking against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10) $display("unexpected result lfo %0d raw %0d",
                                         lfo_value_o, raw_value_o);
        end else begin
          lfo_result_t want;
          want = pending_results.pop_front();
          n_results++;
          if (lfo_value_o !== want.lfo || raw_value_o !== want.raw) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("result %0d: lfo exp %0d got %0d, raw exp %0d got %0d",
                       n_results, want.lfo, lfo_value_o, want.raw, raw_value_o);
          end
        end
      end
      out_ready_i <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  typedef struct {
    bit adv;
    bit rst_orbit;
    bit known;
    int lfo;
    int raw;
  } tick_row_t;

  tick_row_t tick_table[] = '{
    '{0, 0, 1, 0, 0},          // holding after reset
    '{0, 1, 1, 0, 0},          // restart without advance
    '{1, 0, 0, 0, 0},          // first step, logistic
    '{1, 0, 0, 0, 0},
    '{1, 1, 0, 0, 0},          // restart together with advance
    '{1, 0, 0, 0, 0},
    '{0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0}
  };

  initial begin
    int unsigned phase_cfg[6];
    int n_sent;
    cycle_count     = 0;
    n_mismatch      = 0;
    n_results       = 0;
    n_steps         = 0;
    send_idle_pct   = 0;
    recv_idle_pct   = 0;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    advance_i       = 1'b0;
    restart_orbit_i = 1'b0;
    out_ready_i     = 1'b1;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = cml_pkg::REG_MAP_SELECT;
    cfg_data_i      = '0;
    map_r = 0; amount_r = 32768; interval_r = 50;
    coef_r = 0; depth_r = 65535; init_x_r = 8388608;
    reload_orbit();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, then short intervals through every map
    foreach (tick_table[i]) begin
      send_tick(tick_table[i].adv, tick_table[i].rst_orbit);
      if (tick_table[i].known)
        check_known('{cml_pkg::OUT_WIDTH'(tick_table[i].lfo),
                      cml_pkg::OUT_WIDTH'(tick_table[i].raw)});
    end
    drain();
    write_reg(cml_pkg::REG_UPDATE_INTERVAL, 0);        // zero behaves as one
    write_reg(cml_pkg::REG_OUTPUT_DEPTH, 65535);
    write_reg(cml_pkg::REG_SMOOTHING_COEF, 0);
    for (int m = 0; m < 8; m++) begin          // every map plus unused selectors
      drain();
      write_reg(cml_pkg::REG_MAP_SELECT, m);
      write_reg(cml_pkg::REG_CHAOS_AMOUNT, (m % 2) ? 65535 : 0);
      send_tick(1, 1);
      send_tick(1, 0);
    end
    drain();
    write_reg(cml_pkg::REG_UPDATE_INTERVAL, 127);       // above the maximum
    write_reg(cml_pkg::REG_INITIAL_X, 24'hFFFFFF);
    write_reg(cml_pkg::REG_SMOOTHING_COEF, 65535);
    write_reg(cml_pkg::REG_OUTPUT_DEPTH, 0);
    send_tick(1, 1);
    send_tick(1, 0);
    drain();

    // Random: phases of settings and idling patterns
    n_sent = 0;
    for (int ph = 0; ph < 15; ph++) begin
      drain();
      if (ph < 5) begin
        send_idle_pct = 23;
        recv_idle_pct = 52;
      end else if (ph < 10) begin
        send_idle_pct = 52;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      phase_cfg[0] = (ph < 10) ? ph % 5 : $urandom_range(7);
      phase_cfg[1] = (ph == 1) ? 0 : ((ph == 2) ? 65535 : $urandom_range(65535));
      phase_cfg[2] = (ph % 4 == 0) ? $urandom_range(127) : $urandom_range(3);
      phase_cfg[3] = (ph % 3 == 0) ? 0 : $urandom_range(65535);
      phase_cfg[4] = (ph == 3) ? 0 : $urandom_range(65535);
      phase_cfg[5] = $urandom_range(24'hFFFFFF);
      for (int r = 0; r < 6; r++) write_reg(cml_pkg::cfg_reg_e'(r), phase_cfg[r]);
      for (int k = 0; k < N_RANDOM / 15; k++) begin
        send_tick($urandom_range(99) < 85, $urandom_range(99) < 3);
        n_sent++;
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();

    $display("Ran %0d random ticks plus directed rows; %0d results checked, %0d map steps",
             n_sent, n_results, n_steps);
    $display("All five maps, unused selectors, restarts and interval extremes exercised.");
    if (n_mismatch == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", n_mismatch);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
